// ===== rtl/amma_pkg.sv =====
`timescale 1ns / 1ps

package amma_pkg;

	localparam int unsigned WINDOW_DEF = 10;
	localparam int unsigned AXIS_W     = 16;
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned MAG_MAX    = 56755;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned ROOT_STEPS = 16;
	localparam int unsigned AXES       = 3;
	localparam logic [MAG_W-1:0] THRESHOLD_RESET = 16'd410;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SQUARE = 6'b000010,
		ST_ROOT   = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage

// ===== rtl/accel_magnitude_moving_average.sv =====
`timescale 1ns / 1ps
// An item runs through the shared multiplier (3 squares), the 16-step square-root unit
// and a reciprocal multiply for the divide by WINDOW in turn. A new item is taken only
// once the block is back in its idle state, after the last result went to m_tdata.
// A result not yet taken holds the block in its finishing step with s_tready low.
// Reset (arst_n low, asynchronous): window, sum and write position cleared,
// threshold back to 410, no result pending.
module accel_magnitude_moving_average #(
	parameter int unsigned WINDOW = amma_pkg::WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // average_magnitude [15:0], moving [16], zero [23:17]
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import amma_pkg::*;

	localparam int unsigned SW = $clog2(WINDOW * (MAG_MAX + 1));
	localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW = $clog2(ROOT_STEPS);
	localparam int unsigned SH = SW + $clog2(WINDOW);
	localparam longint unsigned RCP_FULL =
		((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [SW:0] RCP = RCP_FULL[SW:0];

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [AXIS_W-1:0]    ax_q, ay_q, az_q;
	logic [SQ_W-1:0]      rad_q;
	logic [16:0]          srem_q;
	logic [MAG_W-1:0]     root_q;
	logic [SW-1:0]        sum_q;
	logic [MAG_W-1:0]     div_q;
	logic [PW-1:0]        wpos_q;
	logic [WINDOW-1:0]    valid_q;
	logic [MAG_W-1:0]     mem [WINDOW];
	logic [MAG_W-1:0]     old_q;
	logic [MAG_W-1:0]     thr_q;
	logic [MAG_W-1:0]     avg_q;
	logic                 moving_q;
	logic                 m_tvalid_q;

	logic [AXIS_W-1:0]    axis_sel;
	logic [AXIS_W:0]      axis_ext;
	logic [AXIS_W:0]      axis_abs;
	logic [2*AXIS_W+1:0]  prod;
	logic [19:0]          root_trial;
	logic [MAG_W-1:0]     old_val;
	logic [SW-1:0]        new_sum;
	logic [2*SW:0]        quot_prod;
	logic                 accept;
	logic                 out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, moving_q, avg_q};

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    axis_sel = ax_q;
			2'd1:    axis_sel = ay_q;
			default: axis_sel = az_q;
		endcase
		axis_ext   = {axis_sel[AXIS_W-1], axis_sel};
		axis_abs   = axis_sel[AXIS_W-1] ? ((AXIS_W+1)'(0) - axis_ext) : axis_ext;
		prod       = axis_abs * axis_abs;
		root_trial = {1'b0, srem_q, rad_q[SQ_W-1:SQ_W-2]} - {2'b00, root_q, 2'b01};
		old_val    = valid_q[wpos_q] ? old_q : '0;
		new_sum    = sum_q - SW'(old_val) + SW'(root_q);
		quot_prod  = sum_q * RCP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		old_q <= mem[wpos_q];
		if (state_q == ST_UPDATE) begin
			mem[wpos_q] <= root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rad_q      <= '0;
			srem_q     <= '0;
			root_q     <= '0;
			sum_q      <= '0;
			div_q      <= '0;
			wpos_q     <= '0;
			valid_q    <= '0;
			avg_q      <= '0;
			moving_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rad_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					rad_q <= rad_q + prod[SQ_W-1:0];
					if (cnt_q == CW'(AXES - 1)) begin
						cnt_q   <= '0;
						srem_q  <= '0;
						root_q  <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					rad_q <= {rad_q[SQ_W-3:0], 2'b00};
					if (!root_trial[19]) begin
						srem_q <= root_trial[16:0];
						root_q <= {root_q[MAG_W-2:0], 1'b1};
					end else begin
						srem_q <= {srem_q[14:0], rad_q[SQ_W-1:SQ_W-2]};
						root_q <= {root_q[MAG_W-2:0], 1'b0};
					end
					if (cnt_q == CW'(ROOT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_UPDATE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					sum_q           <= new_sum;
					valid_q[wpos_q] <= 1'b1;
					if (wpos_q == PW'(WINDOW - 1)) begin
						wpos_q <= '0;
					end else begin
						wpos_q <= wpos_q + 1'b1;
					end
					cnt_q   <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					div_q   <= quot_prod[SH +: MAG_W];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						avg_q      <= div_q;
						moving_q   <= (div_q > thr_q);
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block still ready after taking an item");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finishing step");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SW'(WINDOW * MAG_MAX))
		else $error("window sum beyond the largest possible value");

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= PW'(WINDOW - 1))
		else $error("write position outside the window");

endmodule
